@@ hdl/pngu_pkg.sv @@
// Shared types and constants for the PNG scanline unfilter.
// Used by the top level png_scanline_unfilter and by its checker.
`default_nettype none

package pngu_pkg;

   // One input transaction: a filter byte or a filtered data byte.
   typedef struct packed {
      logic [7:0] byte_in;
      logic       image_start;
   } req_type;

   // One result transaction: a reconstructed byte.
   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       row_end;
   } rsp_type;

   // PNG filter method 0 codes.
   typedef enum logic [2:0] {
      FILTER_NONE    = 3'd0,
      FILTER_SUB     = 3'd1,
      FILTER_UP      = 3'd2,
      FILTER_AVERAGE = 3'd3,
      FILTER_PAETH   = 3'd4
   } filter_type;

   // Register file layout.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_PIXEL_BYTES = 1'b0;
   localparam logic REG_ROW_BYTES   = 1'b1;

   localparam logic [2:0]  PIXEL_BYTES_RESET = 3'd3;
   localparam logic [13:0] ROW_BYTES_RESET   = 14'd3072;

endpackage : pngu_pkg

`default_nettype wire

@@ hdl/png_scanline_unfilter.sv @@
// Top level of the PNG scanline unfilter: row control, predictor and line store.
// Depends on pngu_pkg and pngu_ram.
`default_nettype none

// Reverses PNG filter method 0 on a decompressed, non-interlaced stream of
// 8-bit samples, one byte per transaction. The first byte of every row is the
// filter code and produces no result; each data byte produces one
// reconstructed byte, with row_end set on the last byte of the row. The
// block sustains one byte per clock cycle while results are taken. A result
// is offered once its byte has passed the predictor stage and the output
// register; a stalled result holds the input off once the predictor stage
// behind it is also full. The predictor stage is there for the line store, a
// RAM with a registered read: the entry above is read as the byte is accepted
// and written back with the reconstructed value when the byte leaves the
// predictor stage. The line store needs no clearing pass; the first row of an
// image treats the row above as zero. Write pixel_bytes and row_bytes while
// the block is idle; a row length that grows between rows of one image reads
// line store entries that were never written.
module png_scanline_unfilter #(
   parameter int MAX_ROW_BYTES = 8192
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Input byte stream
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire pngu_pkg::req_type               req_data,
   // Reconstructed byte stream
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output pngu_pkg::rsp_type                    rsp_data,
   // Register access
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [pngu_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [pngu_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [pngu_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                 pready
);

   import pngu_pkg::*;

   localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
   localparam int CNT_W  = $clog2(MAX_ROW_BYTES + 1);
   localparam int LEN_W  = (CNT_W > 14) ? CNT_W : 14;

   // Paeth predictor, ties resolved in the order left, above, upper left.
   function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
      logic [9:0] pa;
      logic [9:0] pb;
      logic [9:0] pc;
      logic [9:0] ab;
      logic [9:0] cc;
      pa = (b > c) ? 10'(b - c) : 10'(c - b);
      pb = (a > c) ? 10'(a - c) : 10'(c - a);
      ab = 10'(a) + 10'(b);
      cc = {1'b0, c, 1'b0};
      pc = (ab > cc) ? (ab - cc) : (cc - ab);
      if (pa <= pb && pa <= pc) begin
         return a;
      end else if (pb <= pc) begin
         return b;
      end else begin
         return c;
      end
   endfunction

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   logic [2:0]        pixel_bytes_ff;
   logic [13:0]       row_bytes_ff;

   logic              want_filter_ff, want_filter_in;
   logic              first_row_ff, first_row_in;
   filter_type        filter_ff, filter_in;
   logic [ADDR_W-1:0] column_ff, column_in;

   // Predictor stage: one data byte whose line store read is in flight.
   logic              s1_valid_ff, s1_valid_in;
   logic [7:0]        s1_byte_ff;
   filter_type        s1_filter_ff;
   logic              s1_first_ff;
   logic              s1_head_ff;
   logic              s1_end_ff;
   logic [1:0]        s1_sel_ff;
   logic [ADDR_W-1:0] s1_col_ff;

   logic [31:0]       left_ff, left_in;
   logic [31:0]       upleft_ff, upleft_in;

   logic              out_valid_ff, out_valid_in;
   rsp_type           out_data_ff;

   // ------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------
   logic csr_write;
   logic csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[2];

   always_comb begin
      prdata = '0;
      unique case (csr_index)
         REG_PIXEL_BYTES: prdata = CSR_DATA_W'(pixel_bytes_ff);
         REG_ROW_BYTES:   prdata = CSR_DATA_W'(row_bytes_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_bytes_ff <= PIXEL_BYTES_RESET;
         row_bytes_ff   <= ROW_BYTES_RESET;
      end else if (csr_write) begin
         if (csr_index == REG_PIXEL_BYTES) begin
            pixel_bytes_ff <= pwdata[2:0];
         end else begin
            row_bytes_ff <= pwdata[13:0];
         end
      end
   end

   // ------------------------------------------------------------------
   // Clamped configuration
   // ------------------------------------------------------------------
   logic [2:0]       bpp;
   logic [LEN_W-1:0] row_len;
   logic [LEN_W-1:0] row_bytes_wide;

   assign row_bytes_wide = LEN_W'(row_bytes_ff);

   always_comb begin
      if (pixel_bytes_ff == 3'd0) begin
         bpp = 3'd1;
      end else if (pixel_bytes_ff > 3'd4) begin
         bpp = 3'd4;
      end else begin
         bpp = pixel_bytes_ff;
      end

      if (row_bytes_wide == '0) begin
         row_len = LEN_W'(1);
      end else if (row_bytes_wide > LEN_W'(MAX_ROW_BYTES)) begin
         row_len = LEN_W'(MAX_ROW_BYTES);
      end else begin
         row_len = row_bytes_wide;
      end
   end

   // ------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------
   logic req_fire;
   logic data_fire;
   logic s1_advance;
   logic out_free;
   logic is_filter;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_fire   = req_valid && !req_stall;
   assign is_filter  = want_filter_ff || req_data.image_start;
   assign data_fire  = req_fire && !is_filter;

   // ------------------------------------------------------------------
   // Row control: filter bytes, column count and row end
   // ------------------------------------------------------------------
   logic [LEN_W-1:0] column_next;
   logic             last_in_row;

   assign column_next = LEN_W'(column_ff) + LEN_W'(1);
   assign last_in_row = column_next >= row_len;

   always_comb begin
      want_filter_in = want_filter_ff;
      first_row_in   = first_row_ff;
      filter_in      = filter_ff;
      column_in      = column_ff;
      if (req_fire) begin
         if (is_filter) begin
            // Filter byte: codes above four act as no filter.
            want_filter_in = 1'b0;
            first_row_in   = first_row_ff || req_data.image_start;
            column_in      = '0;
            if (req_data.byte_in > 8'd4) begin
               filter_in = FILTER_NONE;
            end else begin
               filter_in = filter_type'(req_data.byte_in[2:0]);
            end
         end else if (last_in_row) begin
            want_filter_in = 1'b1;
            first_row_in   = 1'b0;
            column_in      = '0;
         end else begin
            column_in = column_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         want_filter_ff <= 1'b1;
         first_row_ff   <= 1'b1;
         filter_ff      <= FILTER_NONE;
         column_ff      <= '0;
      end else begin
         want_filter_ff <= want_filter_in;
         first_row_ff   <= first_row_in;
         filter_ff      <= filter_in;
         column_ff      <= column_in;
      end
   end

   // ------------------------------------------------------------------
   // Line store: read the byte above on accept, write back when the byte moves on
   // ------------------------------------------------------------------
   logic [7:0] above_rd;
   logic [7:0] recon;

   pngu_ram #(
      .WIDTH (8),
      .DEPTH (MAX_ROW_BYTES)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_advance),
      .wr_addr (s1_col_ff),
      .wr_data (recon),
      .rd_en   (data_fire),
      .rd_addr (column_ff),
      .rd_data (above_rd)
   );

   // ------------------------------------------------------------------
   // Predictor stage
   // ------------------------------------------------------------------
   assign s1_valid_in = data_fire ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Columns before the first full pixel have no left neighbor.
   always_ff @(posedge clock) begin
      if (data_fire) begin
         s1_byte_ff   <= req_data.byte_in;
         s1_filter_ff <= filter_ff;
         s1_first_ff  <= first_row_ff;
         s1_head_ff   <= LEN_W'(column_ff) < LEN_W'(bpp);
         s1_end_ff    <= last_in_row;
         s1_sel_ff    <= 2'(bpp - 3'd1);
         s1_col_ff    <= column_ff;
      end
   end

   logic [7:0] pa_left;
   logic [7:0] pa_above;
   logic [7:0] pa_upleft;
   logic [8:0] pa_sum;
   logic [7:0] pred;

   always_comb begin
      pa_above  = s1_first_ff ? 8'd0 : above_rd;
      pa_left   = left_ff[{s1_sel_ff, 3'b000} +: 8];
      pa_upleft = upleft_ff[{s1_sel_ff, 3'b000} +: 8];
      if (s1_head_ff) begin
         pa_left   = 8'd0;
         pa_upleft = 8'd0;
      end
      pa_sum = 9'(pa_left) + 9'(pa_above);
      unique case (s1_filter_ff)
         FILTER_SUB:     pred = pa_left;
         FILTER_UP:      pred = pa_above;
         FILTER_AVERAGE: pred = pa_sum[8:1];
         FILTER_PAETH:   pred = paeth(pa_left, pa_above, pa_upleft);
         default:        pred = 8'd0;
      endcase
      recon = s1_byte_ff + pred;
   end

   // Recent reconstructed bytes and recent above bytes of this row.
   assign left_in   = s1_advance ? {left_ff[23:0], recon} : left_ff;
   assign upleft_in = s1_advance ? {upleft_ff[23:0], pa_above} : upleft_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         upleft_ff <= '0;
      end else begin
         left_ff   <= left_in;
         upleft_ff <= upleft_in;
      end
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   assign out_valid_in = s1_advance ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_data_ff.pixel_byte <= recon;
         out_data_ff.row_end    <= s1_end_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule : png_scanline_unfilter

`default_nettype wire

@@ hdl/pngu_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module pngu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port; read data holds when not enabled.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : pngu_ram

`default_nettype wire

@@ hdl/pngu_checker.sv @@
// Port-level checks for png_scanline_unfilter, attached with a bind statement.
// Depends on pngu_pkg.
`default_nettype none

module pngu_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire pngu_pkg::rsp_type               rsp_data,
   input wire logic                            psel,
   input wire logic                            penable,
   input wire logic                            pready
);

   // A stalled result transaction holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // The input side waits only while a result waits on the output side.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with the output free");

   // A new result follows an accepted input transaction.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without an accepted input");

   // Reset empties the output side.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The register port never inserts wait states.
   assert property (@(posedge clock) disable iff (reset)
      psel && penable |-> pready)
      else $error("register access not ready");

endmodule : pngu_checker

bind png_scanline_unfilter pngu_checker u_pngu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .psel      (psel),
   .penable   (penable),
   .pready    (pready)
);

`default_nettype wire

@@ tb/sv/png_scanline_unfilter_tb.sv @@
// Self-checking testbench for png_scanline_unfilter: byte stream in, reconstructed bytes out.
// Depends on pngu_pkg and the png_scanline_unfilter RTL; a built-in predictor checks every result.
`timescale 1ns / 1ps

module png_scanline_unfilter_tb;
   import pngu_pkg::*;

   localparam int MAX_ROW      = 8192;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_TICKS = 4;

   // Predicts reconstructed bytes and checks them against the block's results.
   class recon_tracker;
      logic [7:0]  row_above [MAX_ROW];
      logic [31:0] left_hist;
      logic [31:0] upleft_hist;
      int          column;
      filter_type  kind;
      bit          awaiting_filter;
      bit          first_row;
      logic [2:0]  pixel_cfg;
      logic [13:0] row_cfg;
      rsp_type     recon_due[$];
      int          mismatch_count;

      function new();
         left_hist       = '0;
         upleft_hist     = '0;
         column          = 0;
         kind            = FILTER_NONE;
         awaiting_filter = 1'b1;
         first_row       = 1'b1;
         pixel_cfg       = PIXEL_BYTES_RESET;
         row_cfg         = ROW_BYTES_RESET;
         mismatch_count  = 0;
      endfunction

      function void configure(logic index, logic [31:0] value);
         if (index == REG_PIXEL_BYTES) begin
            pixel_cfg = value[2:0];
         end else begin
            row_cfg = value[13:0];
         end
      endfunction

      function int pending();
         return recon_due.size();
      endfunction

      // Standard Paeth choice: left, then above, then upper-left on ties.
      function int paeth_nearest(int a, int b, int c);
         int p, da, db, dc;
         p  = a + b - c;
         da = p - a;
         db = p - b;
         dc = p - c;
         if (da < 0) da = -da;
         if (db < 0) db = -db;
         if (dc < 0) dc = -dc;
         if (da <= db && da <= dc) return a;
         if (db <= dc) return b;
         return c;
      endfunction

      // Called for every accepted input transaction.
      function void take_byte(req_type item);
         int         bpp, len, ia, ib, ic, pred;
         logic [7:0] recon;
         rsp_type    due;
         if (item.image_start) begin
            first_row       = 1'b1;
            awaiting_filter = 1'b1;
         end
         // A filter byte only sets up the row.
         if (awaiting_filter) begin
            if (item.byte_in > 8'(FILTER_PAETH)) begin
               kind = FILTER_NONE;
            end else begin
               kind = filter_type'(item.byte_in[2:0]);
            end
            awaiting_filter = 1'b0;
            column          = 0;
            left_hist       = '0;
            upleft_hist     = '0;
            return;
         end
         bpp = (pixel_cfg == 0) ? 1 : (pixel_cfg > 4) ? 4 : int'(pixel_cfg);
         len = (row_cfg == 0) ? 1 : (row_cfg > MAX_ROW) ? MAX_ROW : int'(row_cfg);
         ia  = int'((left_hist >> (8 * (bpp - 1))) & 32'hFF);
         ic  = int'((upleft_hist >> (8 * (bpp - 1))) & 32'hFF);
         ib  = first_row ? 0 : int'(row_above[column]);
         case (kind)
            FILTER_SUB:     pred = ia;
            FILTER_UP:      pred = ib;
            FILTER_AVERAGE: pred = (ia + ib) / 2;
            FILTER_PAETH:   pred = paeth_nearest(ia, ib, ic);
            default:        pred = 0;
         endcase
         recon = 8'(int'(item.byte_in) + pred);
         row_above[column] = recon;
         left_hist   = {left_hist[23:0], recon};
         upleft_hist = {upleft_hist[23:0], 8'(ib)};
         due.pixel_byte = recon;
         due.row_end    = (column + 1 >= len);
         if (due.row_end) begin
            awaiting_filter = 1'b1;
            first_row       = 1'b0;
            column          = 0;
         end else begin
            column++;
         end
         recon_due = {recon_due, due};
      endfunction

      // Called for every accepted result transaction.
      function void check_pixel(rsp_type got);
         rsp_type due;
         if (recon_due.size() == 0) begin
            $error("pixel_byte %0h arrived with no byte pending", got.pixel_byte);
            mismatch_count++;
            return;
         end
         due = recon_due.pop_front();
         if (got.pixel_byte !== due.pixel_byte) begin
            $error("pixel_byte: expected %0h, actual %0h", due.pixel_byte, got.pixel_byte);
            mismatch_count++;
         end
         if (got.row_end !== due.row_end) begin
            $error("row_end: expected %0b, actual %0b", due.row_end, got.row_end);
            mismatch_count++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   recon_tracker sb = new();
   int           send_gap_pct;
   int           stall_pct;
   int           corner_idx;
   bit           hold_req;

   png_scanline_unfilter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Extreme byte values; they wrap the sums and make Paeth ties likely.
   function automatic logic [7:0] corner_byte(int k);
      case (k % 4)
         0:       return 8'hFF;
         1:       return 8'h00;
         2:       return 8'h80;
         default: return 8'h01;
      endcase
   endfunction

   // Builds the next byte from where the stream stands: a filter byte at a row head,
   // else a data byte. With noise on, some rows start over and some codes are unknown.
   function automatic req_type make_item(input bit start_image, input bit noise);
      req_type item;
      bit      at_head;
      if (start_image) begin
         item.image_start = 1'b1;
      end else if (!noise) begin
         item.image_start = 1'b0;
      end else begin
         item.image_start = ($urandom_range(999) < (sb.awaiting_filter ? 30 : 4));
      end
      at_head = sb.awaiting_filter || item.image_start;
      if (at_head && (!noise || $urandom_range(99) < 85)) begin
         item.byte_in = 8'($urandom_range(int'(FILTER_PAETH)));
      end else if (at_head) begin
         item.byte_in = 8'($urandom_range(255, 5));
      end else if ($urandom_range(99) < 25) begin
         item.byte_in = corner_byte($urandom_range(3));
      end else begin
         item.byte_in = 8'($urandom);
      end
      return item;
   endfunction

   // Offers one transaction after a random gap and returns at the falling edge
   // after it was taken, with valid still high.
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.take_byte(item);
      @(negedge clock);
   endtask

   task automatic send_bytes(input int count);
      req_type item;
      for (int n = 0; n < count; n++) begin
         item.image_start = 1'b0;
         item.byte_in     = corner_byte(corner_idx);
         corner_idx++;
         send_item(item);
      end
   endtask

   task automatic send_row(input logic [7:0] code, input bit start, input int count);
      req_type item;
      item.byte_in     = code;
      item.image_start = start;
      send_item(item);
      send_bytes(count);
   endtask

   task automatic send_random(input int count, input bit start_first, input bit noise);
      for (int n = 0; n < count; n++) send_item(make_item(start_first && n == 0, noise));
   endtask

   // Stops offering and waits until every expected result is in and the
   // block has settled from any trailing filter byte.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   // Setup phase, access phase, then idle.
   task automatic csr_write(input logic index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.configure(index, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Each phase starts a new image, so a longer row never reads stale line entries.
   task automatic run_phase(input logic [2:0] pix, input logic [13:0] row_len,
                            input int gap_pct, input int stall_p, input int count,
                            input bit noise);
      drain_pipeline();
      csr_write(REG_PIXEL_BYTES, 32'(pix));
      csr_write(REG_ROW_BYTES, 32'(row_len));
      send_gap_pct = gap_pct;
      stall_pct    = stall_p;
      send_random(count, 1'b1, noise);
   endtask

   // Receiver: random stalls, or a long hold-off when one is requested.
   initial begin : rsp_stall_driver
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Check every accepted result transaction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_pixel(rsp_data);
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      send_gap_pct = 0;
      stall_pct    = 0;
      corner_idx   = 0;
      hold_req     = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed part. The first row opens at the reset row length; shrinking
      // the length mid-row then closes it on the next byte.
      send_row(FILTER_SUB, 1'b1, 5);
      drain_pipeline();
      csr_write(REG_ROW_BYTES, 3);
      send_bytes(1);
      drain_pipeline();
      // A pixel size of zero acts as one, so left neighbors are adjacent bytes.
      csr_write(REG_PIXEL_BYTES, 0);
      send_row(FILTER_UP, 1'b0, 3);
      send_row(FILTER_AVERAGE, 1'b0, 3);
      send_row(FILTER_PAETH, 1'b0, 3);
      // Unknown code acts as none; the row is cut short by a new image.
      send_row(8'hFF, 1'b0, 1);
      send_row(FILTER_NONE, 1'b1, 3);

      // Random part, no idling, with a long receiver hold-off and a full drain.
      run_phase(3'd3, 14'd24, 0, 0, 150, 1'b1);
      hold_req = 1'b1;
      send_random(80, 1'b0, 1'b1);
      drain_pipeline();
      send_random(60, 1'b0, 1'b1);

      run_phase(3'd4, 14'd32, 55, 0, 200, 1'b1);
      run_phase(3'd3, 14'd1, 0, 55, 150, 1'b1);
      run_phase(3'd7, 14'd0, 32, 32, 120, 1'b1);
      run_phase(3'd2, 14'd7, 0, 55, 200, 1'b1);
      run_phase(3'd5, 14'd20, 32, 32, 200, 1'b1);
      run_phase(3'd1, 14'd9, 55, 0, 150, 1'b1);
      run_phase(3'd4, 14'd300, 0, 0, 150, 1'b1);
      // A row length field above the line store size; the phase ends well
      // before a row would close.
      run_phase(3'd4, 14'h3FFF, 0, 0, 100, 1'b0);

      drain_pipeline();
      repeat (8) @(negedge clock);
      if (sb.mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
